### rtl/core/bpfl_pkg.sv
// bpfl_pkg: types and constants shared by the buffer pool free list
// used by the interfaces, the stack cells, the register block, the top level and the checker
`default_nettype none

package bpfl_pkg;

  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned ACTIVE_W = 9;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned PADDR_W  = 3;

  localparam logic [BYTES_W-1:0]  BUFFER_BYTES_RST   = 16'd64;
  localparam logic [ACTIVE_W-1:0] ACTIVE_BUFFERS_RST = 9'd256;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_BUFFER_BYTES   = 1'b0,
    REG_ACTIVE_BUFFERS = 1'b1
  } reg_idx_t;

  // shift control for every cell of the stack
  typedef struct packed {
    logic load;
    logic push;
    logic pop;
  } stack_ctl_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [BYTES_W-1:0] buffer_bytes;
    logic [COUNT_W-1:0] eff_count;
    logic               rebuild;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/bpfl_if.sv
// bpfl_req_if and bpfl_rsp_if: valid/ready channels of the buffer pool free list
// depends on bpfl_pkg for the field widths
`default_nettype none

interface bpfl_req_if import bpfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [INDEX_W-1:0] buffer_index;

  modport source (output valid, output opcode, output buffer_index, input ready);
  modport sink   (input valid, input opcode, input buffer_index, output ready);
endinterface

interface bpfl_rsp_if import bpfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [INDEX_W-1:0]  granted_index;
  logic [OFFSET_W-1:0] byte_offset;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, output status, output granted_index, output byte_offset,
                  output free_count, input ready);
  modport sink   (input valid, input status, input granted_index, input byte_offset,
                  input free_count, output ready);
endinterface

`default_nettype wire

### rtl/core/bpfl_cell.sv
// bpfl_cell: one entry of the shifting free stack
// depends on bpfl_pkg
`default_nettype none

module bpfl_cell import bpfl_pkg::*; (
  input  wire logic               clk,
  input  wire stack_ctl_t         ctl,
  input  wire logic [INDEX_W-1:0] home,
  input  wire logic [INDEX_W-1:0] from_above,
  input  wire logic [INDEX_W-1:0] from_below,
  output logic      [INDEX_W-1:0] value
);

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      value <= home;
    end else if (ctl.push) begin
      value <= from_above;
    end else if (ctl.pop) begin
      value <= from_below;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bpfl_regs.sv
// bpfl_regs: apb register block, buffer size and active buffer count
// depends on bpfl_pkg
`default_nettype none

module bpfl_regs import bpfl_pkg::*; #(
  parameter int unsigned CELLS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]   pwdata,
  output logic      [APB_W-1:0]   prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  localparam logic [COUNT_W-1:0] CELLS_C = COUNT_W'(CELLS);

  logic [BYTES_W-1:0]  buffer_bytes;
  logic [ACTIVE_W-1:0] active_buffers;
  logic [COUNT_W-1:0]  eff_count;
  logic [COUNT_W-1:0]  eff_next;
  logic                rebuild;
  logic                wr;
  reg_idx_t            sel;

  assign sel    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // zero counts as one, saturate at the stack size
  always_comb begin
    eff_next = pwdata[COUNT_W-1:0];
    if (eff_next == '0) begin
      eff_next = COUNT_W'(1);
    end else if (eff_next > CELLS_C) begin
      eff_next = CELLS_C;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes   <= BUFFER_BYTES_RST;
      active_buffers <= ACTIVE_BUFFERS_RST;
      eff_count      <= CELLS_C;
      rebuild        <= 1'b0;
    end else begin
      rebuild <= 1'b0;
      if (wr) begin
        unique case (sel)
          REG_BUFFER_BYTES: begin
            buffer_bytes <= pwdata[BYTES_W-1:0];
          end
          REG_ACTIVE_BUFFERS: begin
            active_buffers <= pwdata[ACTIVE_W-1:0];
            eff_count      <= eff_next;
            rebuild        <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (sel)
      REG_BUFFER_BYTES:   prdata = APB_W'(buffer_bytes);
      REG_ACTIVE_BUFFERS: prdata = APB_W'(active_buffers);
      default:            prdata = '0;
    endcase
  end

  assign cfg.buffer_bytes = buffer_bytes;
  assign cfg.eff_count    = eff_count;
  assign cfg.rebuild      = rebuild;

endmodule

`default_nettype wire

### rtl/core/buffer_pool_free_list.sv
// buffer_pool_free_list: top level of the fixed-size buffer pool allocator
// depends on bpfl_pkg, bpfl_if, bpfl_cell and bpfl_regs
`default_nettype none

// Fixed-size buffer pool with a last-in-first-out free list. Each request on
// the req channel (allocate or free) yields exactly one transfer on the rsp
// channel, carrying a status, the granted buffer index, its byte offset
// (index times buffer_bytes) and the number of free buffers left. The free
// stack is a row of min(POOL_BUFFERS, 256) cells with the top in cell 0:
// an allocate shifts every cell up by one, a free shifts every cell down and
// places the freed index in cell 0. A bitmap of allocated buffers catches
// double frees; out-of-range indices are refused. One request is taken per
// cycle while req.ready is high; the result is held in the output register
// from the cycle after the request transfer, and a new request is taken
// whenever that register is empty or being drained in the same cycle.
// Writing active_buffers over apb rebuilds the pool in the cycle after the
// write (stack reloaded as 0 on top, bitmap cleared); no request is taken in
// that cycle. No clearing pass is needed after reset. The user must write
// configuration only while no request is outstanding; it is not enforced.
module buffer_pool_free_list import bpfl_pkg::*; #(
  parameter int unsigned POOL_BUFFERS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  bpfl_req_if.sink                req,
  bpfl_rsp_if.source              rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]   pwdata,
  output logic      [APB_W-1:0]   prdata,
  output logic                    pready
);

  // indices are 8 bits, so no more than 256 cells are ever reachable
  localparam int unsigned CELLS = (POOL_BUFFERS < 256) ? POOL_BUFFERS : 256;
  localparam int unsigned IW    = $clog2(CELLS);
  localparam int unsigned DW    = $clog2(CELLS + 1);
  localparam logic [DW-1:0] CELLS_D = DW'(CELLS);

  cfg_t cfg;

  bpfl_regs #(.CELLS(CELLS)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stack state
  logic [INDEX_W-1:0] cell_val [CELLS];
  logic [DW-1:0]      depth;
  logic [DW-1:0]      depth_next;
  logic [CELLS-1:0]   alloc_map;
  stack_ctl_t         ctl;

  // request decode
  logic               accept;
  opcode_t            op;
  logic [INDEX_W-1:0] top;
  status_t            status_c;
  logic [INDEX_W-1:0] granted_c;
  logic               do_pop;
  logic               do_push;

  // output register
  logic                rsp_valid;
  status_t             rsp_status;
  logic [INDEX_W-1:0]  rsp_granted;
  logic [OFFSET_W-1:0] rsp_offset;
  logic [DW-1:0]       rsp_count;

  // hold requests off while a result is stalled or the pool is rebuilt
  assign req.ready = (!rsp_valid || rsp.ready) && !cfg.rebuild;
  assign accept    = req.valid && req.ready;
  assign op        = opcode_t'(req.opcode);
  assign top       = cell_val[0];

  always_comb begin
    status_c  = ST_OK;
    granted_c = '0;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    unique case (op)
      OP_ALLOC: begin
        if (depth == '0) begin
          status_c = ST_EMPTY;
        end else begin
          granted_c = top;
          do_pop    = 1'b1;
        end
      end
      OP_FREE: begin
        priority if (COUNT_W'(req.buffer_index) >= cfg.eff_count) begin
          status_c = ST_RANGE;
        end else if (!alloc_map[req.buffer_index[IW-1:0]]) begin
          status_c = ST_NOT_ALLOC;
        end else begin
          // room check mirrors the bounded stack; the bitmap keeps it true
          do_push = (depth < CELLS_D);
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.load = rst || cfg.rebuild;
  assign ctl.push = accept && do_push;
  assign ctl.pop  = accept && do_pop;

  always_comb begin
    depth_next = depth;
    if (ctl.pop) begin
      depth_next = depth - DW'(1);
    end else if (ctl.push) begin
      depth_next = depth + DW'(1);
    end
  end

  // row of stack cells, cell 0 is the top of the free stack
  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    logic [INDEX_W-1:0] above;
    logic [INDEX_W-1:0] below;
    if (k == 0) begin : g_first
      assign above = req.buffer_index;
    end else begin : g_mid_above
      assign above = cell_val[k-1];
    end
    if (k == CELLS - 1) begin : g_last
      assign below = '0;
    end else begin : g_mid_below
      assign below = cell_val[k+1];
    end
    bpfl_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .home       (INDEX_W'(k)),
      .from_above (above),
      .from_below (below),
      .value      (cell_val[k])
    );
  end

  // free count and allocated bitmap
  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= CELLS_D;
      alloc_map <= '0;
    end else if (cfg.rebuild) begin
      depth     <= cfg.eff_count[DW-1:0];
      alloc_map <= '0;
    end else begin
      depth <= depth_next;
      if (ctl.pop) begin
        alloc_map[top[IW-1:0]] <= 1'b1;
      end else if (ctl.push) begin
        alloc_map[req.buffer_index[IW-1:0]] <= 1'b0;
      end
    end
  end

  // output register, drains independently of the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status  <= status_c;
      rsp_granted <= granted_c;
      // 8 x 16 product fits the 24 bit offset exactly
      rsp_offset  <= OFFSET_W'(granted_c) * OFFSET_W'(cfg.buffer_bytes);
      rsp_count   <= depth_next;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.granted_index = rsp_granted;
  assign rsp.byte_offset   = rsp_offset;
  assign rsp.free_count    = COUNT_W'(rsp_count);

endmodule

`default_nettype wire

### rtl/core/bpfl_checker.sv
// bpfl_checker: port-level assertions for buffer_pool_free_list, and its bind
// depends on bpfl_pkg and buffer_pool_free_list
`default_nettype none

module bpfl_checker import bpfl_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire logic [1:0]          rsp_status,
  input wire logic [INDEX_W-1:0]  rsp_granted_index,
  input wire logic [OFFSET_W-1:0] rsp_byte_offset,
  input wire logic [COUNT_W-1:0]  rsp_free_count
);

  // every request transfer produces a result
  a_req_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("request transfer without result");

  // a pending result is not dropped
  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // failed requests carry no buffer
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> (rsp_granted_index == '0) && (rsp_byte_offset == '0))
    else $error("failed request carries a buffer");

  // free count never exceeds 256
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_free_count <= COUNT_W'(256))
    else $error("free count out of range");

endmodule

bind buffer_pool_free_list bpfl_checker u_bpfl_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_granted_index (rsp.granted_index),
  .rsp_byte_offset   (rsp.byte_offset),
  .rsp_free_count    (rsp.free_count)
);

`default_nettype wire
